// ===== hw/rtl/wtam_pkg.sv =====
// Package for the window threshold alarm monitor.
// Holds register indexes, cause codes, limits and the per-channel state type.
// No dependencies.
`default_nettype none

package wtam_pkg;

    // Channel count range and default.
    localparam int MAX_CHANNELS         = 3;
    localparam int DEFAULT_NUM_CHANNELS = 3;

    // Field widths fixed by the interface.
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 40;
    localparam int COUNT_W = 16;
    localparam int CHAN_W  = 2;
    localparam int CAUSE_W = 2;
    localparam int ADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_1  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT_1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT_2  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT_2 = 3'd5;

    // Reset values of the limits: 0.0 and 1.0 in Q16.16.
    localparam logic signed [DATA_W-1:0] LOW_LIMIT_RESET  = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RESET = 32'sh0001_0000;

    // Command codes.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_ACK   = 1'b1;

    // Alarm cause codes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_UNDER = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_OVER  = 2'd2;

    // Code for "no channel has its reported flag set".
    localparam logic [CHAN_W-1:0] NONE_REPORTED = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // State kept for one alarm channel.
    typedef struct packed {
        logic               active;
        logic               reported;
        logic               acked;
        logic [CAUSE_W-1:0] cause;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } chan_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/window_threshold_alarm_monitor_core.sv =====
// Window threshold alarm monitor, top level.
// Uses wtam_pkg for register indexes, cause codes and the channel state type.
// Usage:
//   The sample channel (sample_valid/sample_stall) carries one command per
//   beat: a check of a signed Q16.16 sample against the addressed channel's
//   window, or an acknowledge of that channel's alarm. The result channel
//   (result_valid/result_stall) returns one beat per command with the
//   addressed channel's flags, cause, count and timestamp plus the aggregate
//   status of all channels, taken after the update.
//   A command is held in the input register and then in the result register.
//   The block takes one command per cycle while result_stall is low; the
//   window compare and flag update sit between the input register and the
//   result register, and the channel state is written at the same edge that
//   loads the result register. When the receiver stalls, the result register
//   holds its beat and the input register still takes one more command
//   before sample_stall rises. Reset clears all alarm state and loads the
//   limits with 0.0 and 1.0. The user writes the limits through the APB port
//   only while the block is idle; the block itself does not enforce this.
`default_nettype none

module window_threshold_alarm_monitor_core #(
    parameter int NUM_CHANNELS = wtam_pkg::DEFAULT_NUM_CHANNELS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wtam_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [wtam_pkg::DATA_W-1:0]         pwdata,
    output logic      [wtam_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready,
    // Sample channel
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire logic                                cmd,
    input  wire logic [wtam_pkg::CHAN_W-1:0]         channel,
    input  wire logic signed [wtam_pkg::DATA_W-1:0]  sample_value,
    input  wire logic [wtam_pkg::STAMP_W-1:0]        time_stamp,
    // Result channel
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     chan_active,
    output logic                                     chan_reported,
    output logic                                     chan_acknowledged,
    output logic      [wtam_pkg::CAUSE_W-1:0]        chan_cause,
    output logic      [wtam_pkg::COUNT_W-1:0]        chan_count,
    output logic      [wtam_pkg::STAMP_W-1:0]        chan_time,
    output logic                                     any_reported,
    output logic                                     any_active,
    output logic                                     all_acknowledged,
    output logic      [wtam_pkg::CHAN_W-1:0]         last_reported
);

    import wtam_pkg::*;

    // Limit registers
    logic signed [DATA_W-1:0] low_limit_reg  [MAX_CHANNELS];
    logic signed [DATA_W-1:0] high_limit_reg [MAX_CHANNELS];
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_write;

    // Input register
    logic                     in_valid_reg;
    logic                     cmd_reg;
    logic [CHAN_W-1:0]        channel_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic [STAMP_W-1:0]       stamp_reg;
    logic                     in_take;
    logic                     advance;

    // Channel state
    chan_state_t              chan_reg  [NUM_CHANNELS];
    chan_state_t              chan_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  lane_hit;
    logic [NUM_CHANNELS-1:0]  lane_under;
    logic [NUM_CHANNELS-1:0]  lane_over;

    // Result values and register
    chan_state_t              sel_state;
    logic                     any_rep_next;
    logic                     any_act_next;
    logic                     all_ack_next;
    logic [CHAN_W-1:0]        last_rep_next;

    logic                     result_valid_reg;
    chan_state_t              res_state_reg;
    logic                     any_rep_reg;
    logic                     any_act_reg;
    logic                     all_ack_reg;
    logic [CHAN_W-1:0]        last_rep_reg;

    // APB decode: pready is tied high, data read straight from the limits.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_LOW_LIMIT_0:  prdata = low_limit_reg[0];
            REG_HIGH_LIMIT_0: prdata = high_limit_reg[0];
            REG_LOW_LIMIT_1:  prdata = low_limit_reg[1];
            REG_HIGH_LIMIT_1: prdata = high_limit_reg[1];
            REG_LOW_LIMIT_2:  prdata = low_limit_reg[2];
            REG_HIGH_LIMIT_2: prdata = high_limit_reg[2];
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                low_limit_reg[i]  <= LOW_LIMIT_RESET;
                high_limit_reg[i] <= HIGH_LIMIT_RESET;
            end
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LOW_LIMIT_0:  low_limit_reg[0]  <= pwdata;
                REG_HIGH_LIMIT_0: high_limit_reg[0] <= pwdata;
                REG_LOW_LIMIT_1:  low_limit_reg[1]  <= pwdata;
                REG_HIGH_LIMIT_1: high_limit_reg[1] <= pwdata;
                REG_LOW_LIMIT_2:  low_limit_reg[2]  <= pwdata;
                REG_HIGH_LIMIT_2: high_limit_reg[2] <= pwdata;
                default:          ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or being drained this cycle.
    assign advance      = in_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign in_take      = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= cmd;
            channel_reg <= channel;
            sample_reg  <= sample_value;
            stamp_reg   <= time_stamp;
        end
    end

    // Per-channel window compare and state update.
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            lane_hit[i]   = advance && (channel_reg == CHAN_W'(i));
            lane_under[i] = sample_reg < low_limit_reg[i];
            lane_over[i]  = sample_reg > high_limit_reg[i];
            chan_next[i]  = chan_reg[i];
            if (lane_hit[i])
            begin
                if (cmd_reg == CMD_ACK)
                begin
                    chan_next[i].acked = 1'b1;
                end
                else if (lane_under[i] || lane_over[i])
                begin
                    // Leaving the window: a new activation is counted once.
                    if (!chan_reg[i].active)
                    begin
                        if (chan_reg[i].count != COUNT_MAX)
                        begin
                            chan_next[i].count = chan_reg[i].count + 1'b1;
                        end
                        chan_next[i].stamp    = stamp_reg;
                        chan_next[i].acked    = 1'b0;
                        chan_next[i].reported = 1'b1;
                    end
                    chan_next[i].active = 1'b1;
                    chan_next[i].cause  = lane_under[i] ? CAUSE_UNDER : CAUSE_OVER;
                    if (chan_next[i].acked)
                    begin
                        chan_next[i].reported = 1'b0;
                    end
                end
                else
                begin
                    chan_next[i].active   = 1'b0;
                    chan_next[i].reported = 1'b0;
                    chan_next[i].acked    = 1'b1;
                    chan_next[i].cause    = CAUSE_NONE;
                    chan_next[i].stamp    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= chan_next[i];
            end
        end
    end

    // Addressed channel's view and aggregate status after the update.
    always_comb
    begin
        sel_state     = '0;
        any_rep_next  = 1'b0;
        any_act_next  = 1'b0;
        all_ack_next  = 1'b1;
        last_rep_next = NONE_REPORTED;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (channel_reg == CHAN_W'(i))
            begin
                sel_state = chan_next[i];
            end
            if (chan_next[i].reported)
            begin
                any_rep_next  = 1'b1;
                last_rep_next = CHAN_W'(i);
            end
            if (chan_next[i].active)
            begin
                any_act_next = 1'b1;
            end
            if (!chan_next[i].acked)
            begin
                all_ack_next = 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_state_reg <= sel_state;
            any_rep_reg   <= any_rep_next;
            any_act_reg   <= any_act_next;
            all_ack_reg   <= all_ack_next;
            last_rep_reg  <= last_rep_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign chan_active       = res_state_reg.active;
    assign chan_reported     = res_state_reg.reported;
    assign chan_acknowledged = res_state_reg.acked;
    assign chan_cause        = res_state_reg.cause;
    assign chan_count        = res_state_reg.count;
    assign chan_time         = res_state_reg.stamp;
    assign any_reported      = any_rep_reg;
    assign any_active        = any_act_reg;
    assign all_acknowledged  = all_ack_reg;
    assign last_reported     = last_rep_reg;

    // An active alarm always carries a cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && res_state_reg.active |-> res_state_reg.cause != CAUSE_NONE)
    else $error("active alarm without cause");

    // An inactive channel reports no cause and no timestamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !res_state_reg.active
            |-> res_state_reg.cause == CAUSE_NONE && res_state_reg.stamp == '0)
    else $error("inactive channel keeps cause or timestamp");

    // Only an active alarm can be pending report.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && res_state_reg.reported |-> res_state_reg.active)
    else $error("reported flag set on inactive channel");

    // A reported channel shows up in the aggregate status.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && res_state_reg.reported
            |-> any_rep_reg && last_rep_reg != NONE_REPORTED)
    else $error("aggregate status misses a reported channel");

    // The input register stalls only while it holds a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg && result_valid_reg && result_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
